// ===== src/lzw_pkg.sv =====
package lzw_pkg;

  localparam int DictEntriesDefault = 65536;
  localparam int MaxStringLenDefault = 64;
  localparam int CodeW = 16;
  localparam int ByteW = 8;
  localparam int LenW = 7;
  localparam int ByteCodes = 256;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             first;
  } item_t;

  typedef struct packed {
    logic [CodeW-1:0] prefix;
    logic [ByteW-1:0] suffix;
    logic [ByteW-1:0] first_byte;
    logic [LenW-1:0]  len;
  } entry_t;

endpackage

// ===== src/lzw_if.sv =====
interface lzw_in_if import lzw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] code;
  logic             first;
  modport source (output valid, output code, output first, input ready);
  modport sink (input valid, input code, input first, output ready);
endinterface

interface lzw_out_if import lzw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             last;
  logic             error;
  modport source (output valid, output data_byte, output last, output error, input ready);
  modport sink (input valid, input data_byte, input last, input error, output ready);
endinterface

// ===== src/lzw_decoder_16bit_unit.sv =====
// Each code is classified, its prefix chain is walked into a byte stack, and the
// L bytes of its string are then handed out; an invalid code gives one result.
// The prefix chain walk reads one dictionary entry per cycle.
// A two-entry input queue accepts codes while the back end is still busy.
// Reset is synchronous and restarts the dictionary at 256 codes; its contents
// are not cleared and only entries written since the stream began are read.
module lzw_decoder_16bit_unit import lzw_pkg::*; #(
  parameter int DICT_ENTRIES = DictEntriesDefault,
  parameter int MAX_STRING_LEN = MaxStringLenDefault
) (
  input  logic      clk,
  input  logic      rst,
  lzw_in_if.sink    in_ch,
  lzw_out_if.source out_ch
);

  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  lzw_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  lzw_back #(
    .DICT_ENTRIES   (DICT_ENTRIES),
    .MAX_STRING_LEN (MAX_STRING_LEN)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

endmodule

// ===== src/lzw_front.sv =====
module lzw_front import lzw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  lzw_in_if.sink   in_ch,
  output item_t    q_item,
  output logic     q_valid,
  input  logic     q_ready
);

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ch.ready = (count != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{code: in_ch.code, first: in_ch.first};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/lzw_back.sv =====
module lzw_back import lzw_pkg::*; #(
  parameter int DICT_ENTRIES = DictEntriesDefault,
  parameter int MAX_STRING_LEN = MaxStringLenDefault
) (
  input  logic     clk,
  input  logic     rst,
  input  item_t    q_item,
  input  logic     q_valid,
  output logic     q_ready,
  lzw_out_if.source out_ch
);

  localparam int AW = $clog2(DICT_ENTRIES);
  localparam int NW = AW + 1;
  localparam int SW = (MAX_STRING_LEN > 2) ? $clog2(MAX_STRING_LEN) : 1;
  localparam logic [NW-1:0] NfcReset = NW'(ByteCodes);
  localparam logic [NW-1:0] NfcFull = NW'(DICT_ENTRIES);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_STRING_LEN);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLASS = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_PREP = 3'd3;
  localparam logic [2:0] ST_POP = 3'd4;
  localparam logic [2:0] ST_ERR = 3'd5;

  entry_t dict [DICT_ENTRIES];
  logic [ByteW-1:0] stack [MAX_STRING_LEN];

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [NW-1:0]    nfc;
  logic [CodeW-1:0] prev_code;
  logic             have_prev;
  logic [CodeW-1:0] cur_code;
  logic             cur_first;
  logic [CodeW-1:0] walk_code;
  logic [LenW-1:0]  walk_idx;
  logic [LenW-1:0]  str_len;
  logic [SW-1:0]    rd_idx;
  logic [SW-1:0]    rd_idx_next;

  entry_t           qa;
  entry_t           qb;
  logic [AW-1:0]    rda_addr;
  logic             dict_we;
  entry_t           dict_wd;
  logic             stk_we;
  logic [SW-1:0]    stk_wa;
  logic [ByteW-1:0] stk_wd;
  logic [ByteW-1:0] stk_q;

  logic [NW-1:0]    nfc_eff;
  logic             hp_eff;
  logic             code_lt;
  logic             kwkwk;
  logic             code_lit;
  logic             prev_lit;
  logic             walk_lit;
  logic [LenW-1:0]  code_len;
  logic [LenW-1:0]  prev_len;
  logic [ByteW-1:0] code_fb;
  logic [ByteW-1:0] prev_fb;
  logic [LenW-1:0]  len;
  logic [ByteW-1:0] cur_fb;
  logic             bad;
  logic             grow;
  logic [ByteW-1:0] walk_byte;
  logic [CodeW-1:0] walk_nc;
  logic             out_free;
  logic             pop_last;

  assign nfc_eff = cur_first ? NfcReset : nfc;
  assign hp_eff = cur_first ? 1'b0 : have_prev;
  assign code_lt = {{(NW > CodeW ? NW - CodeW : 0){1'b0}}, cur_code} < nfc_eff;
  assign kwkwk = ({{(NW > CodeW ? NW - CodeW : 0){1'b0}}, cur_code} == nfc_eff)
                 && hp_eff && (nfc_eff < NfcFull);
  assign code_lit = (cur_code[CodeW-1:ByteW] == '0);
  assign prev_lit = (prev_code[CodeW-1:ByteW] == '0);
  assign code_len = code_lit ? LenW'(1) : qa.len;
  assign prev_len = prev_lit ? LenW'(1) : qb.len;
  assign code_fb = code_lit ? cur_code[ByteW-1:0] : qa.first_byte;
  assign prev_fb = prev_lit ? prev_code[ByteW-1:0] : qb.first_byte;
  assign len = kwkwk ? prev_len + LenW'(1) : code_len;
  assign cur_fb = kwkwk ? prev_fb : code_fb;
  assign bad = !(code_lt || kwkwk) || (len == '0) || (len > MaxLen);
  assign grow = hp_eff && (nfc_eff < NfcFull);

  assign walk_lit = (walk_code[CodeW-1:ByteW] == '0);
  assign walk_byte = walk_lit ? walk_code[ByteW-1:0] : qa.suffix;
  assign walk_nc = walk_lit ? '0 : qa.prefix;

  assign out_free = !out_ch.valid || out_ch.ready;
  assign pop_last = ({{(LenW - SW){1'b0}}, rd_idx} == str_len - LenW'(1));
  assign q_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    rda_addr = q_item.code[AW-1:0];
    dict_we = 1'b0;
    dict_wd = '{prefix: prev_code, suffix: cur_fb, first_byte: prev_fb,
                len: prev_len + LenW'(1)};
    stk_we = 1'b0;
    stk_wa = walk_idx[SW-1:0] - SW'(1);
    stk_wd = walk_byte;
    rd_idx_next = rd_idx;
    case (state)
      ST_IDLE: begin
        if (q_valid) state_next = ST_CLASS;
      end
      ST_CLASS: begin
        if (bad) begin
          state_next = ST_ERR;
        end else begin
          dict_we = grow;
          if (kwkwk) begin
            rda_addr = prev_code[AW-1:0];
            stk_we = 1'b1;
            stk_wa = len[SW-1:0] - SW'(1);
            stk_wd = cur_fb;
          end else begin
            rda_addr = cur_code[AW-1:0];
          end
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        rda_addr = walk_nc[AW-1:0];
        stk_we = 1'b1;
        if (walk_idx == LenW'(1)) begin
          state_next = ST_PREP;
          rd_idx_next = '0;
        end
      end
      ST_PREP: begin
        state_next = ST_POP;
      end
      ST_POP: begin
        if (out_free) begin
          rd_idx_next = rd_idx + SW'(1);
          if (pop_last) state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    qa <= dict[rda_addr];
    qb <= dict[prev_code[AW-1:0]];
    if (dict_we) dict[nfc_eff[AW-1:0]] <= dict_wd;
  end

  always_ff @(posedge clk) begin
    stk_q <= stack[rd_idx_next];
    if (stk_we) stack[stk_wa] <= stk_wd;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      cur_code <= q_item.code;
      cur_first <= q_item.first;
    end
    if (state == ST_CLASS) begin
      str_len <= len;
      walk_code <= kwkwk ? prev_code : cur_code;
      walk_idx <= kwkwk ? len - LenW'(1) : len;
    end else if (state == ST_WALK) begin
      walk_code <= walk_nc;
      walk_idx <= walk_idx - LenW'(1);
    end
    if ((state == ST_POP || state == ST_ERR) && out_free) begin
      out_ch.data_byte <= (state == ST_POP) ? stk_q : '0;
      out_ch.last <= (state == ST_POP) ? pop_last : 1'b1;
      out_ch.error <= (state == ST_ERR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      nfc <= NfcReset;
      prev_code <= '0;
      have_prev <= 1'b0;
      rd_idx <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_idx <= rd_idx_next;
      if (state == ST_CLASS) begin
        if (bad) begin
          nfc <= nfc_eff;
          have_prev <= hp_eff;
        end else begin
          nfc <= grow ? nfc_eff + NW'(1) : nfc_eff;
          prev_code <= cur_code;
          have_prev <= 1'b1;
        end
      end
      if ((state == ST_POP || state == ST_ERR) && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

endmodule
